// ===== hdl/lbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line box filter package
// Widths, register codes, the reciprocal table and the types shared by the
// line box filter modules.
// ----------------------------------------------------------------------------
package lbf_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int GAIN_W        = 8;
   localparam int RADIUS_W      = 5;
   localparam int MAX_RADIUS    = 31;
   localparam int SUM_LINE_LEN  = 2 * MAX_RADIUS + 1;
   localparam int ORIG_LINE_LEN = MAX_RADIUS;
   localparam int SUM_POS_W     = $clog2(SUM_LINE_LEN);
   localparam int ORIG_POS_W    = $clog2(ORIG_LINE_LEN + 1);
   localparam int SUM_W         = 22;
   localparam int RECIP_W       = 17;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIUS = 1'b0,
      CSR_GAIN   = 1'b1
   } csr_index_type;

   // Floor of 65536 over the window size, indexed by radius.
   localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_RADIUS+1] = '{
      17'd65536, 17'd21845, 17'd13107, 17'd9362,  17'd7281,  17'd5957,
      17'd5041,  17'd4369,  17'd3855,  17'd3449,  17'd3120,  17'd2849,
      17'd2621,  17'd2427,  17'd2259,  17'd2114,  17'd1985,  17'd1872,
      17'd1771,  17'd1680,  17'd1598,  17'd1524,  17'd1456,  17'd1394,
      17'd1337,  17'd1285,  17'd1236,  17'd1191,  17'd1149,  17'd1110,
      17'd1074,  17'd1040
   };

   localparam logic [RECIP_W-1:0] RECIP_RESET = 17'd21845;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;

   typedef struct packed {
      logic push;
      logic clear;
   } win_ctrl_type;

   typedef struct packed {
      logic signed [SUM_W-1:0]    sum;
      logic signed [SAMPLE_W-1:0] orig;
      logic                       last;
   } entry_type;

endpackage

// ===== hdl/line_box_filter_with_gain_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line box filter with gain
// Horizontal box filter over a line of signed samples, plus gain times the
// centered sample, with end-of-line flush.
// ----------------------------------------------------------------------------
// Samples enter on the req_ stream, one word per sample, with req_tlast on
// the final sample of a line. Results leave on the rsp_ stream, one word per
// sample, with rsp_tlast on the final result of the line. The csr_ port
// writes the radius and the gain; the user must do so only while the block
// is idle; the block does not enforce it. A radius write also empties the
// window and drops any partial line. Results lag the input by radius
// samples. A result passes the entry register and then the output register
// to rsp_tvalid. One sample is accepted per cycle while req_tready is high.
// After req_tlast the block pushes radius zero samples, one per cycle while
// res_ready is high to flush the rest of the line, holding req_tready low.
// Reset sets the radius to one, the gain to zero and empties the window.
// When the receiver stalls, the output register and the entry register fill
// and then req_tready drops until rsp_tready returns.
// ----------------------------------------------------------------------------
module line_box_filter_with_gain_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lbf_pkg::SAMPLE_W-1:0]          req_tdata,   // sample
   input  logic                                  req_tlast,   // end_of_line
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lbf_pkg::SAMPLE_W-1:0]          rsp_tdata,   // value
   output logic                                  rsp_tlast,   // last
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lbf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [lbf_pkg::CSR_DATA_W-1:0]        csr_data
);
   import lbf_pkg::*;

   logic [RADIUS_W-1:0]        radius_ff, radius_in;
   logic signed [GAIN_W-1:0]   gain_ff, gain_in;
   logic [RECIP_W-1:0]         recip_ff, recip_in;
   logic [RADIUS_W-1:0]        fill_ff, fill_in;
   logic [RADIUS_W-1:0]        count_ff, count_in;
   logic                       flush_ff, flush_in;
   logic                       req_fire;
   logic                       csr_fire;
   logic                       res_ready;
   logic                       emit;
   logic                       emit_last;
   logic                       line_clear;
   win_ctrl_type               win_ctrl;
   logic signed [SAMPLE_W-1:0] push_sample;
   logic signed [SUM_W-1:0]    sum_next;
   logic signed [SAMPLE_W-1:0] orig;
   entry_type                  entry;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = !flush_ff && res_ready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      radius_in  = radius_ff;
      gain_in    = gain_ff;
      recip_in   = recip_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      flush_in   = flush_ff;
      emit       = 1'b0;
      emit_last  = 1'b0;
      line_clear = 1'b0;
      win_ctrl   = '0;

      if (req_fire) begin
         win_ctrl.push = 1'b1;
         emit          = (fill_ff == radius_ff);
         if (fill_ff != radius_ff) begin
            fill_in = fill_ff + RADIUS_W'(1);
         end
         if (req_tlast) begin
            if (radius_ff == '0) begin
               emit_last  = 1'b1;
               line_clear = 1'b1;
            end else begin
               flush_in = 1'b1;
               count_in = radius_ff;
            end
         end
      end else if (flush_ff && res_ready) begin
         win_ctrl.push = 1'b1;
         emit          = (count_ff <= fill_ff);
         emit_last     = (count_ff == RADIUS_W'(1));
         count_in      = count_ff - RADIUS_W'(1);
         if (count_ff == RADIUS_W'(1)) begin
            flush_in   = 1'b0;
            line_clear = 1'b1;
         end
      end

      if (csr_fire) begin
         unique case (csr_index_type'(csr_index))
            CSR_RADIUS: begin
               radius_in  = csr_data[RADIUS_W-1:0];
               recip_in   = RECIP_TABLE[csr_data[RADIUS_W-1:0]];
               line_clear = 1'b1;
            end
            CSR_GAIN: begin
               gain_in = csr_data[GAIN_W-1:0];
            end
         endcase
      end

      if (line_clear) begin
         fill_in = '0;
      end
      win_ctrl.clear = line_clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         gain_ff   <= '0;
         recip_ff  <= RECIP_RESET;
         fill_ff   <= '0;
         count_ff  <= '0;
         flush_ff  <= 1'b0;
      end else begin
         radius_ff <= radius_in;
         gain_ff   <= gain_in;
         recip_ff  <= recip_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         flush_ff  <= flush_in;
      end
   end

   assign push_sample = req_fire ? $signed(req_tdata) : '0;

   lbf_window u_window (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (win_ctrl),
      .sample   (push_sample),
      .radius   (radius_ff),
      .sum_next (sum_next),
      .orig     (orig)
   );

   assign entry.sum  = sum_next;
   assign entry.orig = orig;
   assign entry.last = emit_last;

   lbf_result u_result (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_ctrl.push && emit),
      .in_ready  (res_ready),
      .in_entry  (entry),
      .gain      (gain_ff),
      .recip     (recip_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== hdl/lbf_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line box filter window
// Two zero-filled delay lines with a radius-dependent insertion point and the
// running window sum.
// ----------------------------------------------------------------------------
module lbf_window (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lbf_pkg::win_ctrl_type                 ctrl,
   input  logic signed [lbf_pkg::SAMPLE_W-1:0]   sample,
   input  logic [lbf_pkg::RADIUS_W-1:0]          radius,
   output logic signed [lbf_pkg::SUM_W-1:0]      sum_next,
   output logic signed [lbf_pkg::SAMPLE_W-1:0]   orig
);
   import lbf_pkg::*;

   logic signed [SAMPLE_W-1:0] sum_line_ff [SUM_LINE_LEN];
   logic signed [SAMPLE_W-1:0] orig_line_ff [ORIG_LINE_LEN];
   logic signed [SUM_W-1:0]    sum_ff;
   logic [SUM_POS_W-1:0]       sum_pos;
   logic [ORIG_POS_W-1:0]      orig_pos;

   // The oldest sample of the window always leaves from the last tap.
   assign sum_pos  = SUM_POS_W'(SUM_LINE_LEN - 1) - {radius, 1'b0};
   assign orig_pos = ORIG_POS_W'(ORIG_LINE_LEN) - ORIG_POS_W'(radius);

   assign sum_next = sum_ff + SUM_W'(sample) - SUM_W'(sum_line_ff[SUM_LINE_LEN-1]);
   assign orig     = (radius == '0) ? sample : orig_line_ff[ORIG_LINE_LEN-1];

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int k = 0; k < SUM_LINE_LEN; k++) begin
            sum_line_ff[k] <= '0;
         end
         for (int k = 0; k < ORIG_LINE_LEN; k++) begin
            orig_line_ff[k] <= '0;
         end
         sum_ff <= '0;
      end else if (ctrl.push) begin
         if (sum_pos == '0) begin
            sum_line_ff[0] <= sample;
         end
         for (int k = 1; k < SUM_LINE_LEN; k++) begin
            if (SUM_POS_W'(k) == sum_pos) begin
               sum_line_ff[k] <= sample;
            end else if (SUM_POS_W'(k) > sum_pos) begin
               sum_line_ff[k] <= sum_line_ff[k-1];
            end
         end
         if (orig_pos == '0) begin
            orig_line_ff[0] <= sample;
         end
         for (int k = 1; k < ORIG_LINE_LEN; k++) begin
            if (ORIG_POS_W'(k) == orig_pos) begin
               orig_line_ff[k] <= sample;
            end else if (ORIG_POS_W'(k) > orig_pos) begin
               orig_line_ff[k] <= orig_line_ff[k-1];
            end
         end
         sum_ff <= sum_next;
      end
   end

endmodule

// ===== hdl/lbf_result.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line box filter result stage
// Entry register, scaling of the window sum and the gain product, and the
// output register toward the result channel.
// ----------------------------------------------------------------------------
module lbf_result (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  lbf_pkg::entry_type                   in_entry,
   input  logic signed [lbf_pkg::GAIN_W-1:0]    gain,
   input  logic [lbf_pkg::RECIP_W-1:0]          recip,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [lbf_pkg::SAMPLE_W-1:0]         out_value,
   output logic                                 out_last
);
   import lbf_pkg::*;

   localparam int PROD_W = SUM_W + RECIP_W + 1;
   localparam int GPROD_W = GAIN_W + SAMPLE_W;

   logic                          entry_valid_ff;
   entry_type                     entry_ff;
   logic                          out_valid_ff;
   logic [SAMPLE_W-1:0]           value_ff;
   logic                          last_ff;
   logic                          out_free;
   logic signed [PROD_W-1:0]      avg_prod;
   logic signed [GPROD_W-1:0]     gain_prod;
   logic [SAMPLE_W-1:0]           value_in;

   assign out_free = !out_valid_ff || out_ready;
   assign in_ready = !entry_valid_ff || out_free;

   assign avg_prod  = entry_ff.sum * $signed({1'b0, recip});
   assign gain_prod = gain * entry_ff.orig;
   assign value_in  = gain_prod[SAMPLE_W-1:0] + avg_prod[SAMPLE_W+15:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (in_valid && in_ready) begin
            entry_valid_ff <= 1'b1;
         end else if (out_free) begin
            entry_valid_ff <= 1'b0;
         end
         if (out_free) begin
            out_valid_ff <= entry_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         entry_ff <= in_entry;
      end
      if (out_free) begin
         value_ff <= value_in;
         last_ff  <= entry_ff.last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = value_ff;
   assign out_last  = last_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line box filter with gain testbench
// Drives lines of samples and register writes into the filter, predicts every
// result word with a behavioral copy of the filter or from the directed table,
// and compares each result word field by field. The directed table comes
// first, then random lines under random radius and gain settings, with random
// idling on both streams and one long receiver stall.
// ----------------------------------------------------------------------------
module testbench;

   import lbf_pkg::*;

   localparam int WORD_TARGET    = 520;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type index;
      logic [7:0]    data;
      logic [15:0]   sample;
      logic          eol;
      logic          typed;
      logic [15:0]   want_value;
      logic          want_last;
   } row_type;

   typedef struct packed {
      logic        typed;
      logic [15:0] value;
      logic        last;
   } note_type;

   typedef struct packed {
      logic [15:0] value;
      logic        last;
   } result_type;

   localparam int SCRIPT_LEN = 24;
   localparam row_type SCRIPT [SCRIPT_LEN] = '{
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h7FFF, 1'b1, 1'b1, 16'h2AAA, 1'b1},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h8000, 1'b1, 1'b1, 16'hD555, 1'b1},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  CSR_GAIN,   8'h7F, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  CSR_RADIUS, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h7FFF, 1'b1, 1'b1, 16'hFF80, 1'b1},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h0001, 1'b0, 1'b1, 16'h0080, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h8000, 1'b1, 1'b1, 16'h0000, 1'b1},
      '{ROW_CSR,  CSR_GAIN,   8'h80, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h8000, 1'b1, 1'b1, 16'h8000, 1'b1},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h7FFF, 1'b1, 1'b1, 16'h807F, 1'b1},
      '{ROW_CSR,  CSR_RADIUS, 8'h1F, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h5555, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  CSR_RADIUS, 8'h02, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'hAAAA, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  CSR_RADIUS, 8'h03, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CSR_RADIUS, 8'h00, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  CSR_GAIN,   8'h01, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0}
   };

   localparam logic [15:0] SAMPLE_CORNERS [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
   localparam logic [7:0]  GAIN_CORNERS [5]   = '{8'h7F, 8'h80, 8'h00, 8'h01, 8'hFF};

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata;    // sample
   logic                   req_tlast;    // end_of_line
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [SAMPLE_W-1:0]    rsp_tdata;    // value
   logic                   rsp_tlast;    // last
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Filter state as seen by the predictor.
   logic signed [15:0] window [SUM_LINE_LEN];
   int                 window_total;
   int                 head;
   int                 filled;
   int                 span;
   int                 recip;
   int                 radius_cfg;
   int                 gain_cfg;

   result_type expected_results [$];
   note_type   word_notes [$];

   int errors          = 0;
   int words_sent      = 0;
   int words_accepted  = 0;
   int lines_accepted  = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   bit held_off        = 1'b0;

   line_box_filter_with_gain_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void clear_window();
      foreach (window[i]) window[i] = '0;
      window_total = 0;
      head         = 0;
      filled       = 0;
   endfunction

   function automatic void set_radius(input logic [RADIUS_W-1:0] r);
      radius_cfg = int'(r);
      span       = 2 * radius_cfg + 1;
      recip      = (1 << 16) / span;
      clear_window();
   endfunction

   function automatic void shift_in(input logic signed [15:0] x);
      window_total = window_total - window[head] + x;
      window[head] = x;
      head         = (head + 1) % span;
   endfunction

   // The centered sample sits radius positions behind the newest one.
   function automatic void emit_result(input logic last);
      int          pos;
      longint      product;
      longint      total;
      result_type  res;
      pos     = (head + span - 1 - radius_cfg) % span;
      product = longint'(window_total) * longint'(recip);
      total   = longint'(gain_cfg) * longint'(window[pos]) + (product >>> 16);
      res.value = total[15:0];
      res.last  = last;
      expected_results.push_back(res);
   endfunction

   function automatic void filter_sample(input logic [15:0] s, input logic eol,
                                         input note_type note);
      int first;
      first = expected_results.size();
      shift_in(s);
      if (filled < radius_cfg) begin
         filled++;
      end else begin
         emit_result(eol && radius_cfg == 0);
      end
      if (eol) begin
         for (int k = filled; k < radius_cfg; k++) shift_in('0);
         for (int k = 0; k < filled; k++) begin
            shift_in('0);
            emit_result(k + 1 == filled);
         end
         clear_window();
      end
      if (note.typed && expected_results.size() > first) begin
         expected_results[first].value = note.value;
         expected_results[first].last  = note.last;
      end
   endfunction

   function automatic bit steady_send();
      return words_sent >= 250 && words_sent < 330;
   endfunction

   task automatic send_word(input logic [15:0] s, input logic eol, input note_type note);
      while (!steady_send() && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      word_notes.push_back(note);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= eol;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] d);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : monitor
      note_type   note;
      result_type want;
      if (reset) begin
         gain_cfg = 0;
         set_radius(RADIUS_RESET);
      end else begin
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index_type'(csr_index))
               CSR_RADIUS: set_radius(csr_data[RADIUS_W-1:0]);
               CSR_GAIN:   gain_cfg = int'($signed(csr_data));
               default:    ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            note = word_notes.pop_front();
            filter_sample(req_tdata, req_tlast, note);
            words_accepted++;
            if (req_tlast) lines_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, actual value %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.value) begin
                  errors++;
                  $display("%0t: value mismatch, expected %h, actual %h",
                           $time, want.value, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  errors++;
                  $display("%0t: last mismatch, expected %b, actual %b",
                           $time, want.last, rsp_tlast);
               end
            end
         end
      end
   end

   // The receiver stalls once for a long stretch while samples keep coming.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && results_checked >= 150 && req_tvalid) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= (results_checked >= 250 && results_checked < 330) ||
                       ($urandom_range(99) >= 13);
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      note_type    plain;
      int          cur_radius;
      int          lines;
      int          len;
      bit          partial;
      bit          do_radius;
      logic [7:0]  gain_val;
      logic [15:0] s;
      plain      = '0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_RADIUS;
      csr_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == ROW_CSR) begin
            write_csr(SCRIPT[i].index, SCRIPT[i].data);
         end else begin
            send_word(SCRIPT[i].sample, SCRIPT[i].eol,
                      '{SCRIPT[i].typed, SCRIPT[i].want_value, SCRIPT[i].want_last});
         end
      end
      cur_radius = 3;

      while (words_sent < WORD_TARGET) begin
         do_radius = $urandom_range(3) != 0;
         if (do_radius || $urandom_range(3) != 0) begin
            gain_val = ($urandom_range(99) < 20) ? GAIN_CORNERS[$urandom_range(4)]
                                                 : 8'($urandom);
            write_csr(CSR_GAIN, gain_val);
         end
         if (do_radius) begin
            case ($urandom_range(6))
               0, 1, 2: cur_radius = $urandom_range(3);
               3, 4:    cur_radius = $urandom_range(12, 4);
               5:       cur_radius = $urandom_range(30, 13);
               default: cur_radius = MAX_RADIUS;
            endcase
            write_csr(CSR_RADIUS, 8'(cur_radius));
         end
         lines   = $urandom_range(4, 1);
         partial = $urandom_range(99) < 20;
         for (int l = 0; l < lines; l++) begin
            if ($urandom_range(3) == 0)
               len = $urandom_range(cur_radius > 1 ? cur_radius : 1, 1);
            else
               len = $urandom_range(2 * cur_radius + 10, 1);
            for (int p = 0; p < len; p++) begin
               s = ($urandom_range(99) < 15) ? SAMPLE_CORNERS[$urandom_range(3)]
                                             : 16'($urandom);
               send_word(s, (p == len - 1) && !(partial && l == lines - 1), plain);
            end
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d expected words never arrived, expected %h, actual none",
                  $time, expected_results.size(), expected_results[0].value);
         errors += expected_results.size();
      end
      $display("Sent %0d samples in %0d complete lines across %0d register writes.",
               words_accepted, lines_accepted, csr_writes);
      $display("Compared %0d result words, %0d errors found.", results_checked, errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
